// ----- src/box_blur_3x3_rgb_macros.svh -----
// Assertion helpers shared by the blur block.
// Both expect signals named clk and arst_n in the module that uses them.
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BB3_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define BB3_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/bb3_pkg.sv -----
package bb3_pkg;

	// Sizes and limits
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int CFG_W          = 12;
	localparam int CFG_IDX_W      = 2;
	localparam int POS_W          = 11;
	localparam int HEIGHT_MAX     = 2048;
	localparam int SIZE_MIN       = 3;
	localparam int WIDTH_RST      = 640;
	localparam int HEIGHT_RST     = 480;
	localparam int IN_DATA_W      = 24;
	localparam int OUT_DATA_W     = 48;
	localparam int OUT_PAD_W      = OUT_DATA_W - 24 - 2 * POS_W;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Divide by nine: multiply by 2^16/9 rounded up, exact for sums up to 9*255
	localparam logic [12:0] DIV9_MUL   = 13'd7282;
	localparam int          DIV9_SHIFT = 16;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic [11:0] blue;
		logic [11:0] green;
		logic [11:0] red;
	} sum_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic             last;
	} pos_t;

	function automatic logic [7:0] div9(input logic [11:0] s);
		logic [24:0] p;
		p = 25'(s) * 25'(DIV9_MUL);
		return p[DIV9_SHIFT +: 8];
	endfunction

endpackage

// ----- src/bb3_line_buf.sv -----
// Two line memories: the row above and the row two above the incoming pixel.
// Read at accept, written back once the item leaves the first stage.
module bb3_line_buf #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
	parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  bb3_pkg::pix_t wr_pix,
	output bb3_pkg::pix_t top,
	output bb3_pkg::pix_t mid
);

	bb3_pkg::pix_t mid_mem [MAX_WIDTH];
	bb3_pkg::pix_t top_mem [MAX_WIDTH];
	bb3_pkg::pix_t top_q;
	bb3_pkg::pix_t mid_q;

	// registered reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			top_q <= top_mem[rd_addr];
			mid_q <= mid_mem[rd_addr];
		end
	end

	// row above moves up one line, new pixel becomes the row above
	always_ff @(posedge clk) begin
		if (wr_en) begin
			top_mem[wr_addr] <= mid_q;
			mid_mem[wr_addr] <= wr_pix;
		end
	end

	assign top = top_q;
	assign mid = mid_q;

endmodule

// ----- src/bb3_window.sv -----
// 3x3 window kept as per-column channel sums; two past columns plus the current one.
module bb3_window (
	input  logic          clk,
	input  logic          advance,
	input  bb3_pkg::pix_t top,
	input  bb3_pkg::pix_t mid,
	input  bb3_pkg::pix_t px,
	output bb3_pkg::sum_t sum
);

	typedef struct packed {
		logic [9:0] blue;
		logic [9:0] green;
		logic [9:0] red;
	} csum_t;

	csum_t cur;
	csum_t cs1_q;
	csum_t cs2_q;

	// column sum of the current column
	always_comb begin
		cur.red   = 10'(top.red)   + 10'(mid.red)   + 10'(px.red);
		cur.green = 10'(top.green) + 10'(mid.green) + 10'(px.green);
		cur.blue  = 10'(top.blue)  + 10'(mid.blue)  + 10'(px.blue);
	end

	// full window sum
	always_comb begin
		sum.red   = 12'(cs2_q.red)   + 12'(cs1_q.red)   + 12'(cur.red);
		sum.green = 12'(cs2_q.green) + 12'(cs1_q.green) + 12'(cur.green);
		sum.blue  = 12'(cs2_q.blue)  + 12'(cs1_q.blue)  + 12'(cur.blue);
	end

	// shift columns
	always_ff @(posedge clk) begin
		if (advance) begin
			cs2_q <= cs1_q;
			cs1_q <= cur;
		end
	end

endmodule

// ----- src/bb3_div_out.sv -----
// Sum stage, divide by nine, and the output register.
module bb3_div_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bb3_pkg::sum_t in_sum,
	input  bb3_pkg::pos_t in_pos,
	output logic          out_valid,
	input  logic          out_ready,
	output bb3_pkg::pix_t out_pix,
	output bb3_pkg::pos_t out_pos
);

	logic          s2_valid_s2;
	bb3_pkg::sum_t sum_s2;
	bb3_pkg::pos_t pos_s2;
	logic          out_valid_q;
	bb3_pkg::pix_t pix_q;
	bb3_pkg::pos_t pos_q;
	logic          out_load;

	assign out_load = s2_valid_s2 && (!out_valid_q || out_ready);
	assign in_ready = !s2_valid_s2 || out_load;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid) begin
				s2_valid_s2 <= 1'b1;
			end else if (out_load) begin
				s2_valid_s2 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid) begin
			sum_s2 <= in_sum;
			pos_s2 <= in_pos;
		end
		if (out_load) begin
			pix_q.red   <= bb3_pkg::div9(sum_s2.red);
			pix_q.green <= bb3_pkg::div9(sum_s2.green);
			pix_q.blue  <= bb3_pkg::div9(sum_s2.blue);
			pos_q       <= pos_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = pix_q;
	assign out_pos   = pos_q;

endmodule

// ----- src/box_blur_3x3_rgb.sv -----
// 3x3 box blur on an RGB pixel stream.
// s_axis takes one pixel per transfer in raster order; tdata holds red,
// green, blue from the lowest byte up. m_axis gives one result per interior
// pixel: the 3x3 channel sums divided by nine (truncated), with the column
// and row of the centre pixel; tlast marks the last interior pixel of the
// frame. Border pixels give no result.
// cfg writes image_width (index 0) and image_height (index 1); values are
// clamped to [3, MAX_WIDTH] and [3, 2048]. Write them only while idle.
// Throughput: one pixel per cycle while m_axis does not stall, set by the line
// memories, each with one read port (used at accept) and one write port (used
// as the pixel leaves the first stage, after its read).
// Each result is registered in the first stage (line read), the sum stage
// (window sum) and the output register (divide) before it is valid on m_axis.
// Reset clears the column/row counters and all stage valids and restores
// 640x480; line memories hold whatever was in them until rewritten.
// When m_axis stalls, the stages fill and s_axis_tready drops; nothing is
// dropped and border pixels keep flowing while a result waits.
`include "box_blur_3x3_rgb_macros.svh"

module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bb3_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // red_in, green_in, blue_in
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// red_out, green_out, blue_out, pixel_column, pixel_row, zero pad
	output logic [bb3_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                             m_axis_tlast,  // frame_last
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]        cfg_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = ($clog2(MAX_WIDTH + 1) > bb3_pkg::CFG_W) ?
		$clog2(MAX_WIDTH + 1) : bb3_pkg::CFG_W;
	localparam int W_RST = (bb3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bb3_pkg::WIDTH_RST;
	localparam int PW = bb3_pkg::POS_W;

	// configuration, kept as last column / last row in use
	logic [CW-1:0]                w_last_q;
	logic [bb3_pkg::CFG_W-1:0]    h_last_q;
	logic [CW-1:0]                w_sat;
	logic [bb3_pkg::CFG_W-1:0]    h_sat;
	logic                         cfg_fire;

	// counters
	logic [PW-1:0]                col_q;
	logic [PW-1:0]                row_q;
	logic [CW-1:0]                col_ext;
	logic [bb3_pkg::CFG_W-1:0]    row_ext;
	logic [AW-1:0]                idx;
	logic                         in_fire;

	// first stage
	logic                         s1_valid_s1;
	bb3_pkg::pix_t                px_s1;
	logic [AW-1:0]                idx_s1;
	logic                         res_s1;
	bb3_pkg::pos_t                pos_s1;
	logic                         s1_adv;

	bb3_pkg::pix_t                in_pix;
	bb3_pkg::pix_t                top_rd;
	bb3_pkg::pix_t                mid_rd;
	bb3_pkg::sum_t                win_sum;
	logic                         s2_ready;
	bb3_pkg::pix_t                out_pix;
	bb3_pkg::pos_t                out_pos;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// clamp written sizes
	always_comb begin
		if (cfg_data < bb3_pkg::CFG_W'(bb3_pkg::SIZE_MIN)) begin
			w_sat = CW'(bb3_pkg::SIZE_MIN);
		end else if (CW'(cfg_data) > CW'(MAX_WIDTH)) begin
			w_sat = CW'(MAX_WIDTH);
		end else begin
			w_sat = CW'(cfg_data);
		end
		if (cfg_data < bb3_pkg::CFG_W'(bb3_pkg::SIZE_MIN)) begin
			h_sat = bb3_pkg::CFG_W'(bb3_pkg::SIZE_MIN);
		end else if (cfg_data > bb3_pkg::CFG_W'(bb3_pkg::HEIGHT_MAX)) begin
			h_sat = bb3_pkg::CFG_W'(bb3_pkg::HEIGHT_MAX);
		end else begin
			h_sat = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(W_RST - 1);
			h_last_q <= bb3_pkg::CFG_W'(bb3_pkg::HEIGHT_RST - 1);
		end else if (cfg_fire) begin
			if (cfg_index == bb3_pkg::REG_IMAGE_WIDTH) begin
				w_last_q <= w_sat - CW'(1);
			end else if (cfg_index == bb3_pkg::REG_IMAGE_HEIGHT) begin
				h_last_q <= h_sat - bb3_pkg::CFG_W'(1);
			end
		end
	end

	// input side
	assign in_pix        = bb3_pkg::pix_t'({s_axis_tdata[23:16], s_axis_tdata[15:8],
		s_axis_tdata[7:0]});
	assign s1_adv        = s1_valid_s1 && (!res_s1 || s2_ready);
	assign s_axis_tready = !s1_valid_s1 || s1_adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign col_ext       = CW'(col_q);
	assign row_ext       = bb3_pkg::CFG_W'(row_q);
	assign idx           = (col_ext >= CW'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : col_ext[AW-1:0];

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (col_ext >= w_last_q) begin
				col_q <= '0;
				row_q <= (row_ext >= h_last_q) ? '0 : row_q + PW'(1);
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	// first stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// first stage payload: pixel, address, result decision and position
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1       <= in_pix;
			idx_s1      <= idx;
			res_s1      <= (col_q >= PW'(2)) && (row_q >= PW'(2)) &&
				(col_ext <= w_last_q) && (row_ext <= h_last_q);
			pos_s1.col  <= col_q - PW'(1);
			pos_s1.row  <= row_q - PW'(1);
			pos_s1.last <= (col_ext == w_last_q) && (row_ext == h_last_q);
		end
	end

	bb3_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (idx),
		.wr_en   (s1_adv),
		.wr_addr (idx_s1),
		.wr_pix  (px_s1),
		.top     (top_rd),
		.mid     (mid_rd)
	);

	bb3_window u_window (
		.clk     (clk),
		.advance (s1_adv),
		.top     (top_rd),
		.mid     (mid_rd),
		.px      (px_s1),
		.sum     (win_sum)
	);

	bb3_div_out u_div_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_adv && res_s1),
		.in_ready  (s2_ready),
		.in_sum    (win_sum),
		.in_pos    (pos_s1),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix),
		.out_pos   (out_pos)
	);

	// output packing
	assign m_axis_tdata = {bb3_pkg::OUT_PAD_W'(0), out_pos.row, out_pos.col,
		out_pix.blue, out_pix.green, out_pix.red};
	assign m_axis_tlast = out_pos.last;

	// checks
	`BB3_ASSERT_IMP(a_ready_when_empty, !s1_valid_s1, s_axis_tready, "input blocked with empty first stage")
	`BB3_ASSERT_NXT(a_accept_fills_s1, in_fire, s1_valid_s1, "accepted pixel missing from first stage")
	`BB3_ASSERT_NXT(a_s1_holds, s1_valid_s1 && !s1_adv, s1_valid_s1 && $stable(idx_s1), "stalled first stage changed")

endmodule

// ----- tb/tb_box_blur_3x3_rgb.sv -----
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_AT        = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_TARGET  = 1700;

	// Index values beyond the register list, which the block must ignore
	localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_FULL, PIX_ZERO} pix_mode_t;

	typedef struct {
		logic [7:0]                red;
		logic [7:0]                green;
		logic [7:0]                blue;
		logic [bb3_pkg::POS_W-1:0] col;
		logic [bb3_pkg::POS_W-1:0] row;
		logic                      last;
	} blur_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [bb3_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [bb3_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           m_axis_tlast;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bb3_pkg::CFG_W-1:0]      cfg_data = '0;

	box_blur_3x3_rgb u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: size registers, two line buffers, window, position
	logic [bb3_pkg::CFG_W-1:0] width_reg = bb3_pkg::CFG_W'(bb3_pkg::WIDTH_RST);
	logic [bb3_pkg::CFG_W-1:0] height_reg = bb3_pkg::CFG_W'(bb3_pkg::HEIGHT_RST);
	bb3_pkg::pix_t             line_above [bb3_pkg::MAX_WIDTH_DEF];
	bb3_pkg::pix_t             line_above2 [bb3_pkg::MAX_WIDTH_DEF];
	bb3_pkg::pix_t             window_px [6];
	int                        next_col = 0;
	int                        next_row = 0;

	bb3_pkg::pix_t             pixel_feed_q[$];
	blur_result_t              blur_expect_q[$];

	int src_idle_pct = 15;
	int snk_idle_pct = 15;
	int error_count = 0;
	int pixels_in = 0;
	int results_checked = 0;
	int frames_sent = 0;
	int size_settings = 0;
	int random_items = 0;
	int stall_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input int got_v, input int want_v);
		if (error_count < 100)
			$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got_v,
				want_v);
		error_count++;
	endtask

	// Advance the blur predictor by one accepted pixel
	function automatic void blur_predict(input bb3_pkg::pix_t px);
		int            w, h, c, r, idx, k;
		int            sum_r, sum_g, sum_b;
		bb3_pkg::pix_t nb [9];
		blur_result_t  res;
		w = int'(width_reg);
		if (w < bb3_pkg::SIZE_MIN) w = bb3_pkg::SIZE_MIN;
		if (w > bb3_pkg::MAX_WIDTH_DEF) w = bb3_pkg::MAX_WIDTH_DEF;
		h = int'(height_reg);
		if (h < bb3_pkg::SIZE_MIN) h = bb3_pkg::SIZE_MIN;
		if (h > bb3_pkg::HEIGHT_MAX) h = bb3_pkg::HEIGHT_MAX;
		c = next_col;
		r = next_row;
		idx = (c < bb3_pkg::MAX_WIDTH_DEF) ? c : bb3_pkg::MAX_WIDTH_DEF - 1;
		for (k = 0; k < 6; k++)
			nb[k] = window_px[k];
		nb[6] = line_above2[idx];
		nb[7] = line_above[idx];
		nb[8] = px;
		line_above2[idx] = line_above[idx];
		line_above[idx] = px;

		// Interior pixel: centre is one column left and one row up
		if (c >= 2 && r >= 2 && c < w && r < h) begin
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			for (k = 0; k < 9; k++) begin
				sum_r += nb[k].red;
				sum_g += nb[k].green;
				sum_b += nb[k].blue;
			end
			res.red   = 8'(sum_r / 9);
			res.green = 8'(sum_g / 9);
			res.blue  = 8'(sum_b / 9);
			res.col   = bb3_pkg::POS_W'(c - 1);
			res.row   = bb3_pkg::POS_W'(r - 1);
			res.last  = (c == w - 1 && r == h - 1);
			blur_expect_q.push_back(res);
		end

		for (k = 0; k < 3; k++) begin
			window_px[k] = window_px[k + 3];
			window_px[k + 3] = nb[k + 6];
		end

		if (c >= w - 1) begin
			next_col = 0;
			next_row = (r >= h - 1) ? 0 : ((r + 1) & 'h7FF);
		end else begin
			next_col = (c + 1) & 'h7FF;
		end
	endfunction

	function automatic bb3_pkg::pix_t make_pixel(input pix_mode_t mode);
		bb3_pkg::pix_t px;
		case (mode)
			PIX_FULL: begin
				px = '1;
			end
			PIX_ZERO: begin
				px = '0;
			end
			PIX_EXTREME: begin
				px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
				px.green = $urandom_range(1) ? 8'hFF : 8'h00;
				px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: begin
				px = bb3_pkg::pix_t'($urandom);
			end
		endcase
		return px;
	endfunction

	// Wait until no pixel is pending and every expected result has come
	task automatic wait_drained();
		while (pixel_feed_q.size() > 0 || s_axis_tvalid || blur_expect_q.size() > 0)
			@(negedge clk);
	endtask

	// Drain, then give the pipeline time to finish border pixels
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
		input logic [bb3_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			bb3_pkg::REG_IMAGE_WIDTH: begin
				width_reg = val;
			end
			bb3_pkg::REG_IMAGE_HEIGHT: begin
				height_reg = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic set_size(input logic [bb3_pkg::CFG_W-1:0] w_val,
		input logic [bb3_pkg::CFG_W-1:0] h_val);
		write_reg(bb3_pkg::REG_IMAGE_WIDTH, w_val);
		write_reg(bb3_pkg::REG_IMAGE_HEIGHT, h_val);
		size_settings++;
	endtask

	// Queue one whole frame at the current size; optionally stop halfway until drained
	task automatic queue_frame(input pix_mode_t mode, input bit pause_mid, input bit is_random);
		int w, h, n;
		w = int'(width_reg);
		if (w < bb3_pkg::SIZE_MIN) w = bb3_pkg::SIZE_MIN;
		if (w > bb3_pkg::MAX_WIDTH_DEF) w = bb3_pkg::MAX_WIDTH_DEF;
		h = int'(height_reg);
		if (h < bb3_pkg::SIZE_MIN) h = bb3_pkg::SIZE_MIN;
		if (h > bb3_pkg::HEIGHT_MAX) h = bb3_pkg::HEIGHT_MAX;
		for (n = 0; n < w * h; n++) begin
			if (pause_mid && n == (w * h) / 2)
				wait_drained();
			pixel_feed_q.push_back(make_pixel(mode));
		end
		if (is_random)
			random_items += w * h;
		frames_sent++;
	endtask

	// Pixel driver: one NBA per signal per edge, tvalid held until transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				blur_predict(bb3_pkg::pix_t'(s_axis_tdata));
				pixels_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_feed_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pixel_feed_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random backpressure and one long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin : monitor
			blur_result_t want;
			if (m_axis_tvalid && m_axis_tready) begin
				if (blur_expect_q.size() == 0) begin
					report_mismatch("result with none pending, column",
						int'(m_axis_tdata[34:24]), -1);
				end else begin
					want = blur_expect_q.pop_front();
					if (m_axis_tdata[7:0] !== want.red)
						report_mismatch("red", int'(m_axis_tdata[7:0]), int'(want.red));
					if (m_axis_tdata[15:8] !== want.green)
						report_mismatch("green", int'(m_axis_tdata[15:8]), int'(want.green));
					if (m_axis_tdata[23:16] !== want.blue)
						report_mismatch("blue", int'(m_axis_tdata[23:16]), int'(want.blue));
					if (m_axis_tdata[34:24] !== want.col)
						report_mismatch("column", int'(m_axis_tdata[34:24]), int'(want.col));
					if (m_axis_tdata[45:35] !== want.row)
						report_mismatch("row", int'(m_axis_tdata[45:35]), int'(want.row));
					if (m_axis_tlast !== want.last)
						report_mismatch("frame last", int'(m_axis_tlast), int'(want.last));
				end
				results_checked++;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (results_checked >= HOLD_AT && !hold_done) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", quiet_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		int nfr, phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: smallest frame saturated, clamped sizes, truncation, ignored indexes
		set_size(12'd3, 12'd3);
		queue_frame(PIX_FULL, 1'b0, 1'b0);
		settle();
		set_size(12'd0, 12'd2);
		queue_frame(PIX_EXTREME, 1'b0, 1'b0);
		settle();
		write_reg(REG_SPARE_2, 12'hFFF);
		write_reg(REG_SPARE_3, 12'h005);
		set_size(12'd1, 12'd1);
		queue_frame(PIX_ZERO, 1'b0, 1'b0);
		settle();

		// Frame large enough that the long output hold lands inside it
		set_size(12'd24, 12'd12);
		queue_frame(PIX_RANDOM, 1'b0, 1'b1);
		settle();

		// Sender stops halfway until everything has come out
		set_size(12'd17, 12'd9);
		queue_frame(PIX_RANDOM, 1'b1, 1'b1);
		settle();

		// Random sizes, back-to-back frames per setting
		phase = 0;
		while (random_items < RANDOM_TARGET) begin
			phase++;
			src_idle_pct = (phase % 5 == 2) ? 0 : 15;
			snk_idle_pct = src_idle_pct;
			set_size(($urandom_range(99) < 10) ? bb3_pkg::CFG_W'($urandom_range(2))
					: bb3_pkg::CFG_W'($urandom_range(3, 20)),
				($urandom_range(99) < 10) ? bb3_pkg::CFG_W'($urandom_range(2))
					: bb3_pkg::CFG_W'($urandom_range(3, 10)));
			nfr = $urandom_range(1, 3);
			repeat (nfr) begin
				if (random_items < RANDOM_TARGET) begin
					case ($urandom_range(9))
						7: queue_frame(PIX_EXTREME, 1'b0, 1'b1);
						8: queue_frame(PIX_FULL, 1'b0, 1'b1);
						9: queue_frame(PIX_ZERO, 1'b0, 1'b1);
						default: queue_frame(PIX_RANDOM, 1'b0, 1'b1);
					endcase
				end
			end
			settle();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("covered %0d frames over %0d size settings: %0d pixels in, %0d results checked",
			frames_sent, size_settings, pixels_in, results_checked);
		$display("sizes from clamped 3x3 up to 24 columns, spare indexes, long hold, %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
